@@ design/hgn_pkg.sv @@
// Shared types and constants for the hex grid neighbor enumerator.
// Used by every module of the block but hgn_queue; depends on nothing.
package hgn_pkg;

    // Payload and config field widths
    localparam int IDX_W  = 16;
    localparam int CFG_W  = 9;

    // APB port geometry: four 32-bit registers at byte addresses 0, 4, 8, 12
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Register reset values
    localparam logic [CFG_W-1:0] X_SIZE_RST = 9'd16;
    localparam logic [CFG_W-1:0] Y_SIZE_RST = 9'd16;
    localparam logic             WRAP_X_RST = 1'b0;
    localparam logic             WRAP_Y_RST = 1'b0;

    // Register map, by word address
    typedef enum logic [1:0] {
        REG_X_SIZE = 2'd0,
        REG_Y_SIZE = 2'd1,
        REG_WRAP_X = 2'd2,
        REG_WRAP_Y = 2'd3
    } t_reg;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [CFG_W-1:0] x_size;
        logic [CFG_W-1:0] y_size;
        logic             wrap_x;
        logic             wrap_y;
    } t_cfg;

    // Front end sequencer states
    typedef enum logic [1:0] {
        F_IDLE = 2'd0,
        F_DIV  = 2'd1,
        F_PUSH = 2'd2
    } t_fstate;

    // Neighbor slots in emission order
    localparam int NSLOT = 6;
    typedef enum logic [2:0] {
        SLOT_UP        = 3'd0,
        SLOT_UP_DIAG   = 3'd1,
        SLOT_LEFT      = 3'd2,
        SLOT_RIGHT     = 3'd3,
        SLOT_DOWN      = 3'd4,
        SLOT_DOWN_DIAG = 3'd5
    } t_slot;

endpackage

@@ design/hex_grid_neighbor_enumerator_top.sv @@
// Top level of the hex grid neighbor enumerator: APB registers, front end,
// split queue, back end and result queue. Depends on hgn_pkg and all submodules.
// Path: an accepted cell runs the divider steps and waits in the split queue, then
//   its neighbors pass the back end and the result queue.
// Throughput: the front end takes a new cell only while idle or pushing the last one;
//   the back end emits one neighbor per cycle while the result queue has room.
// Reset: synchronous, active low; registers return to 16 x 16, no wrap; queues empty.
module hex_grid_neighbor_enumerator_top #(
    parameter int MAX_SIDE = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [hgn_pkg::IDX_W-1:0]   i_cell_index,
    output logic                        empty,
    input  logic                        pop,
    output logic [hgn_pkg::IDX_W-1:0]   o_neighbor_index,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hgn_pkg::APB_AW-1:0]  paddr,
    input  logic [hgn_pkg::APB_DW-1:0]  pwdata,
    output logic [hgn_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import hgn_pkg::*;

    // Sides above what the 9-bit registers can hold never clamp
    localparam int SIDE_EFF = (MAX_SIDE < 511) ? MAX_SIDE : 511;
    localparam int SW       = $clog2(SIDE_EFF + 1);
    localparam int QW       = $clog2(SIDE_EFF);
    localparam int MID_W    = SW + QW;
    localparam int OUT_W    = IDX_W + 1;

    t_cfg             w_cfg;
    logic [SW-1:0]    w_w;
    logic [SW-1:0]    w_h;
    logic             w_mid_push;
    logic             w_mid_full;
    logic             w_mid_pop;
    logic             w_mid_empty;
    logic [SW-1:0]    w_fx;
    logic [QW-1:0]    w_fy;
    logic [MID_W-1:0] w_mid_head;
    logic             w_out_push;
    logic             w_out_full;
    logic [IDX_W-1:0] w_bidx;
    logic             w_blast;
    logic [OUT_W-1:0] w_out_head;

    hgn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Clamp the grid sides
    assign w_w = (int'(w_cfg.x_size) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(w_cfg.x_size);
    assign w_h = (int'(w_cfg.y_size) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(w_cfg.y_size);

    hgn_front #(.SW(SW), .QW(QW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cell_index (i_cell_index),
        .o_full       (full),
        .i_w          (w_w),
        .i_h          (w_h),
        .i_wrap_x     (w_cfg.wrap_x),
        .i_wrap_y     (w_cfg.wrap_y),
        .o_q_push     (w_mid_push),
        .o_q_x        (w_fx),
        .o_q_y        (w_fy),
        .i_q_full     (w_mid_full)
    );

    hgn_queue #(.WIDTH(MID_W), .DEPTH(2)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  ({w_fx, w_fy}),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_empty (w_mid_empty),
        .o_data  (w_mid_head)
    );

    hgn_back #(.SW(SW), .QW(QW)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_w              (w_w),
        .i_h              (w_h),
        .i_wrap_x         (w_cfg.wrap_x),
        .i_wrap_y         (w_cfg.wrap_y),
        .i_mid_empty      (w_mid_empty),
        .i_mid_x          (w_mid_head[MID_W-1:QW]),
        .i_mid_y          (w_mid_head[QW-1:0]),
        .o_mid_pop        (w_mid_pop),
        .i_out_full       (w_out_full),
        .o_out_push       (w_out_push),
        .o_neighbor_index (w_bidx),
        .o_last           (w_blast)
    );

    hgn_queue #(.WIDTH(OUT_W), .DEPTH(2)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  ({w_bidx, w_blast}),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_out_head)
    );

    assign o_neighbor_index = w_out_head[OUT_W-1:1];
    assign o_last           = w_out_head[0];

endmodule

@@ design/hgn_cfg.sv @@
// APB register block: grid size and wrap mode registers.
// Depends on hgn_pkg for the register map and the config struct.
module hgn_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hgn_pkg::APB_AW-1:0]  paddr,
    input  logic [hgn_pkg::APB_DW-1:0]  pwdata,
    output logic [hgn_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output hgn_pkg::t_cfg               o_cfg
);
    import hgn_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_reg w_sel;
    logic w_wr;

    assign w_sel  = t_reg'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Decode the write beat
    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (w_sel)
                REG_X_SIZE: n_cfg.x_size = pwdata[CFG_W-1:0];
                REG_Y_SIZE: n_cfg.y_size = pwdata[CFG_W-1:0];
                REG_WRAP_X: n_cfg.wrap_x = pwdata[0];
                REG_WRAP_Y: n_cfg.wrap_y = pwdata[0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{x_size: X_SIZE_RST, y_size: Y_SIZE_RST,
                       wrap_x: WRAP_X_RST, wrap_y: WRAP_Y_RST};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back the addressed register
    always_comb begin
        prdata = '0;
        case (w_sel)
            REG_X_SIZE: prdata[CFG_W-1:0] = r_cfg.x_size;
            REG_Y_SIZE: prdata[CFG_W-1:0] = r_cfg.y_size;
            REG_WRAP_X: prdata[0]         = r_cfg.wrap_x;
            REG_WRAP_Y: prdata[0]         = r_cfg.wrap_y;
            default:    prdata            = '0;
        endcase
    end

endmodule

@@ design/hgn_queue.sv @@
// Small register queue used between front and back and at the result side.
// Self-contained; no package dependency.
module hgn_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    function automatic logic [AW-1:0] f_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Store the incoming beat
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= f_next(r_wp);
            end
            if (w_pop) begin
                r_rp <= f_next(r_rp);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue fill count above depth");

endmodule

@@ design/hgn_front.sv @@
// Front end: range and mode check, then index split into column and row
// by a two-bit-per-cycle restoring divider. Depends on hgn_pkg.
module hgn_front #(
    parameter int SW = 9,
    parameter int QW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [hgn_pkg::IDX_W-1:0]  i_cell_index,
    output logic                       o_full,
    input  logic [SW-1:0]              i_w,
    input  logic [SW-1:0]              i_h,
    input  logic                       i_wrap_x,
    input  logic                       i_wrap_y,
    output logic                       o_q_push,
    output logic [SW-1:0]              o_q_x,
    output logic [QW-1:0]              o_q_y,
    input  logic                       i_q_full
);
    import hgn_pkg::*;

    localparam int NCYC  = (QW + 1) / 2;
    localparam int QB    = 2 * NCYC;
    localparam int DVW   = SW + QB;
    localparam int CMPW  = (DVW > IDX_W) ? DVW : IDX_W;
    localparam int CNT_W = (NCYC > 1) ? $clog2(NCYC) : 1;

    t_fstate          r_state;
    t_fstate          n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [IDX_W-1:0] r_rem;
    logic [IDX_W-1:0] n_rem;
    logic [QB-1:0]    r_quo;
    logic [QB-1:0]    n_quo;
    logic [DVW-1:0]   r_dv;
    logic [DVW-1:0]   n_dv;
    logic [2*SW-1:0]  w_area;
    logic             w_drop;
    logic             w_can_take;
    logic             w_load;
    logic [CMPW-1:0]  w_ra;
    logic [CMPW-1:0]  w_rb;
    logic [CMPW-1:0]  w_d1;
    logic [CMPW-1:0]  w_d0;
    logic             w_ba;
    logic             w_bb;

    // Classify: index outside the grid or row wrap alone yields nothing
    assign w_area = (2*SW)'(i_w) * (2*SW)'(i_h);
    assign w_drop = (32'(i_cell_index) >= 32'(w_area)) || (i_wrap_y && !i_wrap_x);

    assign w_can_take = (r_state == F_IDLE) || ((r_state == F_PUSH) && !i_q_full);
    assign o_full     = !w_can_take;
    assign w_load     = w_can_take && i_push && !w_drop;

    // Two restoring division steps per cycle
    assign w_d1 = CMPW'(r_dv) << 1;
    assign w_d0 = CMPW'(r_dv);
    assign w_ra = CMPW'(r_rem);
    assign w_ba = (w_ra >= w_d1);
    assign w_rb = w_ba ? (w_ra - w_d1) : w_ra;
    assign w_bb = (w_rb >= w_d0);

    assign o_q_x = r_rem[SW-1:0];
    assign o_q_y = r_quo[QW-1:0];

    // Next state and datapath control
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_dv     = r_dv;
        o_q_push = 1'b0;
        case (r_state)
            F_IDLE: begin
                n_state = F_IDLE;
            end
            F_DIV: begin
                n_rem = w_bb ? IDX_W'(w_rb - w_d0) : IDX_W'(w_rb);
                n_quo = (r_quo << 2) | QB'({w_ba, w_bb});
                n_dv  = r_dv >> 2;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NCYC - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_q_push = 1'b1;
                    n_state  = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
        if (w_load) begin
            n_state = F_DIV;
            n_cnt   = '0;
            n_rem   = i_cell_index;
            n_quo   = '0;
            n_dv    = DVW'(i_w) << (QB - 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dv  <= n_dv;
    end

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_DIV && r_cnt == CNT_W'(NCYC - 1)) |=> (r_state == F_PUSH))
        else $error("divider did not finish after its fixed step count");

    a_push_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_PUSH && i_q_full)
            |=> (r_state == F_PUSH && $stable(r_rem) && $stable(r_quo)))
        else $error("split result changed while waiting for queue space");

endmodule

@@ design/hgn_back.sv @@
// Back end: walks the six neighbor slots of one split cell and emits the valid ones,
// one beat per cycle while the result queue has room, flagging the last. Depends on hgn_pkg.
module hgn_back #(
    parameter int SW = 9,
    parameter int QW = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [SW-1:0]              i_w,
    input  logic [SW-1:0]              i_h,
    input  logic                       i_wrap_x,
    input  logic                       i_wrap_y,
    input  logic                       i_mid_empty,
    input  logic [SW-1:0]              i_mid_x,
    input  logic [QW-1:0]              i_mid_y,
    output logic                       o_mid_pop,
    input  logic                       i_out_full,
    output logic                       o_out_push,
    output logic [hgn_pkg::IDX_W-1:0]  o_neighbor_index,
    output logic                       o_last
);
    import hgn_pkg::*;

    localparam int PRW = SW + QW + 1;

    logic [NSLOT-1:0] r_sent;
    logic [NSLOT-1:0] n_sent;
    logic             w_x_lo;
    logic             w_x_hi;
    logic             w_y_lo;
    logic             w_y_hi;
    logic [SW-1:0]    w_prevx;
    logic [SW-1:0]    w_nextx;
    logic [SW-1:0]    w_dcol;
    logic [QW-1:0]    w_prevy;
    logic [QW-1:0]    w_nexty;
    logic             w_up;
    logic             w_down;
    logic             w_left;
    logic             w_right;
    logic             w_diag;
    logic [NSLOT-1:0] w_valid;
    logic [NSLOT-1:0] w_rem;
    logic [NSLOT-1:0] w_pick_oh;
    t_slot            w_pick;
    logic             w_any;
    logic             w_last;
    logic [SW-1:0]    w_col;
    logic [QW-1:0]    w_row;
    logic [PRW-1:0]   w_sum;

    // Edge tests and wrapped neighbor coordinates
    assign w_x_lo  = (i_mid_x == '0);
    assign w_x_hi  = (i_mid_x == i_w - SW'(1));
    assign w_y_lo  = (i_mid_y == '0);
    assign w_y_hi  = (SW'(i_mid_y) == i_h - SW'(1));
    assign w_prevx = w_x_lo ? (i_w - SW'(1)) : (i_mid_x - SW'(1));
    assign w_nextx = w_x_hi ? '0 : (i_mid_x + SW'(1));
    assign w_prevy = w_y_lo ? QW'(i_h - SW'(1)) : (i_mid_y - QW'(1));
    assign w_nexty = w_y_hi ? '0 : (i_mid_y + QW'(1));
    // Diagonals sit right of the column on odd rows, left on even rows
    assign w_dcol  = i_mid_y[0] ? w_nextx : w_prevx;

    assign w_up    = i_wrap_y || !w_y_lo;
    assign w_down  = i_wrap_y || !w_y_hi;
    assign w_left  = i_wrap_x || !w_x_lo;
    assign w_right = i_wrap_x || !w_x_hi;
    assign w_diag  = i_mid_y[0] ? w_right : w_left;

    assign w_valid = {w_down && w_diag, w_down, w_right, w_left, w_up && w_diag, w_up};
    assign w_rem   = w_valid & ~r_sent;

    // Pick the earliest slot not yet sent
    always_comb begin
        w_pick = SLOT_UP;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (w_rem[i]) begin
                w_pick = t_slot'(3'(i));
            end
        end
    end

    assign w_any     = (w_rem != '0);
    assign w_pick_oh = NSLOT'(1) << w_pick;
    assign w_last    = ((w_rem & ~w_pick_oh) == '0);

    // Select coordinates of the picked slot
    always_comb begin
        case (w_pick)
            SLOT_UP:        begin w_col = i_mid_x;  w_row = w_prevy;  end
            SLOT_UP_DIAG:   begin w_col = w_dcol;   w_row = w_prevy;  end
            SLOT_LEFT:      begin w_col = w_prevx;  w_row = i_mid_y;  end
            SLOT_RIGHT:     begin w_col = w_nextx;  w_row = i_mid_y;  end
            SLOT_DOWN:      begin w_col = i_mid_x;  w_row = w_nexty;  end
            SLOT_DOWN_DIAG: begin w_col = w_dcol;   w_row = w_nexty;  end
            default:        begin w_col = i_mid_x;  w_row = i_mid_y;  end
        endcase
    end

    assign w_sum            = PRW'(w_row) * PRW'(i_w) + PRW'(w_col);
    assign o_neighbor_index = IDX_W'(w_sum);
    assign o_last           = w_last;

    // One beat per cycle unless the result queue is full; drop the cell after its last slot
    always_comb begin
        n_sent     = r_sent;
        o_mid_pop  = 1'b0;
        o_out_push = 1'b0;
        if (!i_mid_empty) begin
            if (!w_any) begin
                o_mid_pop = 1'b1;
                n_sent    = '0;
            end else if (!i_out_full) begin
                o_out_push = 1'b1;
                if (w_last) begin
                    o_mid_pop = 1'b1;
                    n_sent    = '0;
                end else begin
                    n_sent = r_sent | w_pick_oh;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent <= '0;
        end else begin
            r_sent <= n_sent;
        end
    end

    a_pop_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mid_pop |=> (r_sent == '0))
        else $error("slot mask not cleared after cell retired");

    a_mid_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && !w_last) |=> (r_sent != '0))
        else $error("sent slot not recorded");

endmodule

@@ tb/hex_grid_neighbor_enumerator_top_tb.sv @@
// Self-checking testbench for the hex grid neighbor enumerator top level.
// Depends on hgn_pkg and hex_grid_neighbor_enumerator_top; predicts neighbor beats
// in a small scoreboard class, drives push and APB with plain tasks, and pops at random.
`timescale 1ns / 100ps

module hex_grid_neighbor_enumerator_top_tb;
    import hgn_pkg::*;

    localparam int SIDE_CAP     = 256;
    localparam int DRAIN_CYCLES = 120;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_nb;

    // Shadow registers, neighbor prediction and result checking
    class neighbor_book;
        t_nb          pending[$];
        int           errors;
        logic [CFG_W-1:0] x_size;
        logic [CFG_W-1:0] y_size;
        logic             wrap_x;
        logic             wrap_y;

        function new();
            errors = 0;
            x_size = X_SIZE_RST;
            y_size = Y_SIZE_RST;
            wrap_x = WRAP_X_RST;
            wrap_y = WRAP_Y_RST;
        endfunction

        function void set_reg(input t_reg r, input logic [APB_DW-1:0] v);
            case (r)
                REG_X_SIZE: x_size = v[CFG_W-1:0];
                REG_Y_SIZE: y_size = v[CFG_W-1:0];
                REG_WRAP_X: wrap_x = v[0];
                REG_WRAP_Y: wrap_y = v[0];
                default: ;
            endcase
        endfunction

        // Predict the neighbor beats of one accepted cell
        function void note_cell(input logic [IDX_W-1:0] cidx);
            int unsigned w, h, x, y, px, nx, py, ny, dcol;
            bit odd, up, dn, lf, rt, dg;
            logic [IDX_W-1:0] nb[$];
            t_nb e;
            w = (x_size > SIDE_CAP) ? SIDE_CAP : x_size;
            h = (y_size > SIDE_CAP) ? SIDE_CAP : y_size;
            // zero size, outside the grid, and row wrap alone give nothing
            if (w == 0 || h == 0 || cidx >= w * h || (wrap_y && !wrap_x))
                return;
            x = cidx % w;
            y = cidx / w;
            odd = y[0];
            px = (x == 0) ? w - 1 : x - 1;
            nx = (x + 1 == w) ? 0 : x + 1;
            py = (y == 0) ? h - 1 : y - 1;
            ny = (y + 1 == h) ? 0 : y + 1;
            if (wrap_x) begin
                lf = 1;
                rt = 1;
                dg = 1;
                dcol = odd ? nx : px;
                up = wrap_y || y > 0;
                dn = wrap_y || y + 1 < h;
            end else begin
                lf = x > 0;
                rt = x + 1 < w;
                dg = odd ? rt : lf;
                dcol = odd ? x + 1 : x - (x > 0 ? 1 : 0);
                up = y > 0;
                dn = y + 1 < h;
            end
            // emit in order: up, up-diagonal, left, right, down, down-diagonal
            if (up) begin
                nb.push_back(IDX_W'(x + py * w));
                if (dg) nb.push_back(IDX_W'(dcol + py * w));
            end
            if (lf) nb.push_back(IDX_W'(px + y * w));
            if (rt) nb.push_back(IDX_W'(nx + y * w));
            if (dn) begin
                nb.push_back(IDX_W'(x + ny * w));
                if (dg) nb.push_back(IDX_W'(dcol + ny * w));
            end
            foreach (nb[i]) begin
                e.idx  = nb[i];
                e.last = (i == nb.size() - 1);
                pending.push_back(e);
            end
        endfunction

        // Compare one popped beat against the oldest prediction
        function void check_neighbor(input logic [IDX_W-1:0] idx, input logic lst);
            t_nb e;
            if (pending.size() == 0) begin
                $error("unexpected neighbor beat: neighbor_index %0d last %0b", idx, lst);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx) begin
                $error("neighbor_index: expected %0d, got %0d", e.idx, idx);
                errors++;
            end
            if (lst !== e.last) begin
                $error("last: expected %0b, got %0b", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [IDX_W-1:0]  i_cell_index = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic [IDX_W-1:0]  o_neighbor_index;
    logic              o_last;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int           snd_idle = 30;
    int           rcv_idle = 78;
    int unsigned  cycles = 0;
    neighbor_book book = new();

    hex_grid_neighbor_enumerator_top #(.MAX_SIDE(SIDE_CAP)) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_cell_index     (i_cell_index),
        .empty            (empty),
        .pop              (pop),
        .o_neighbor_index (o_neighbor_index),
        .o_last           (o_last),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Pop side: check each accepted beat, then stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty)
                book.check_neighbor(o_neighbor_index, o_last);
            pop <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // APB write: setup beat, then access beat until pready
    task automatic write_reg(input t_reg r, input logic [APB_DW-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        book.set_reg(r, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold push low until every predicted beat is out, then drain in-flight cells
    task automatic settle();
        push <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_grid(input int xs, input int ys, input bit wx, input bit wy);
        settle();
        write_reg(REG_X_SIZE, xs);
        write_reg(REG_Y_SIZE, ys);
        write_reg(REG_WRAP_X, APB_DW'(wx));
        write_reg(REG_WRAP_Y, APB_DW'(wy));
    endtask

    // Push one cell beat, idling at random first
    task automatic send_cell(input logic [IDX_W-1:0] cidx);
        while ($urandom_range(0, 99) < snd_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push         <= 1'b1;
        i_cell_index <= cidx;
        do @(posedge i_clk); while (full);
        book.note_cell(cidx);
    endtask

    // Pick a grid, mostly small, and return its cell count
    task automatic random_grid(output int unsigned cells);
        int xs, ys, r;
        bit wx, wy;
        r = $urandom_range(0, 99);
        xs = (r < 70) ? $urandom_range(1, 12) : (r < 85) ? $urandom_range(13, 255) :
             (r < 93) ? SIDE_CAP : $urandom_range(257, 511);
        r = $urandom_range(0, 99);
        ys = (r < 70) ? $urandom_range(1, 12) : (r < 85) ? $urandom_range(13, 255) :
             (r < 93) ? SIDE_CAP : $urandom_range(257, 511);
        r = $urandom_range(0, 99);
        wx = (r >= 30 && r < 90);
        wy = (r >= 60);
        set_grid(xs, ys, wx, wy);
        cells = ((xs > SIDE_CAP) ? SIDE_CAP : xs) * ((ys > SIDE_CAP) ? SIDE_CAP : ys);
    endtask

    initial begin
        int unsigned cells;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset grid, 16 x 16 without wrap: corners, edges, interior, outside
        send_cell(0);
        send_cell(15);
        send_cell(16);
        send_cell(31);
        send_cell(17);
        send_cell(34);
        send_cell(255);
        send_cell(256);
        send_cell(16'hFFFF);

        // Largest grid, plain and fully wrapped
        set_grid(256, 256, 0, 0);
        send_cell(16'hFFFF);
        send_cell(0);
        send_cell(16'h5555);
        set_grid(256, 256, 1, 1);
        send_cell(0);
        send_cell(16'hFFFF);
        send_cell(255);

        // Isolated cell, width one with wrap, row wrap alone
        set_grid(1, 1, 0, 0);
        send_cell(0);
        set_grid(1, 5, 1, 0);
        send_cell(0);
        send_cell(2);
        send_cell(4);
        set_grid(4, 4, 0, 1);
        send_cell(5);

        // Zero width, oversized sizes, last row under column wrap alone
        set_grid(0, 16, 0, 0);
        send_cell(0);
        set_grid(511, 300, 0, 0);
        send_cell(1000);
        set_grid(4, 4, 1, 0);
        send_cell(12);
        send_cell(15);

        // Random grids; swap idling after four grids, then run without idling after eight
        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                snd_idle = 78;
                rcv_idle = 30;
            end
            if (p == 8) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            random_grid(cells);
            for (int k = 0; k < 20; k++) begin
                if (p == 5 && k == 10)
                    settle();
                if ($urandom_range(0, 99) < 85)
                    send_cell(IDX_W'($urandom_range(0, cells - 1)));
                else
                    send_cell(IDX_W'($urandom_range(0, 16'hFFFF)));
            end
        end

        settle();
        if (book.errors == 0 && book.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ hex_grid_neighbor_enumerator_top.f @@
design/hgn_pkg.sv
design/hgn_cfg.sv
design/hgn_queue.sv
design/hgn_front.sv
design/hgn_back.sv
design/hex_grid_neighbor_enumerator_top.sv
tb/hex_grid_neighbor_enumerator_top_tb.sv
